// ===== hdl/planar_shadow_vertex_projector_assert.svh =====
// Assertion shorthands shared by the projector modules.
`ifndef PLANAR_SHADOW_VERTEX_PROJECTOR_ASSERT_SVH
`define PLANAR_SHADOW_VERTEX_PROJECTOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is low.
`define PSVP_ASSERT_IMPL(lbl, c, r, pre, post) \
    lbl: assert property (@(posedge c) disable iff (!r) (pre) |-> (post)) \
        else $error("psvp: same-cycle check failed");

// Next-cycle implication, switched off while reset is low.
`define PSVP_ASSERT_NEXT(lbl, c, r, pre, post) \
    lbl: assert property (@(posedge c) disable iff (!r) (pre) |=> (post)) \
        else $error("psvp: next-cycle check failed");

`endif

// ===== hdl/psvp_pkg.sv =====
package psvp_pkg;

    // Default number of fraction bits
    localparam int FRAC_BITS_DEF = 16;

    localparam int FX_W = 32;

    typedef logic signed [FX_W-1:0] fx_t;
    typedef fx_t [2:0] vec3_t;

    localparam fx_t FX_MAX = 32'sh7fff_ffff;
    localparam fx_t FX_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

    // Register map
    typedef enum logic [2:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_OFFSET   = 3'd3,
        REG_LIGHT_X  = 3'd4,
        REG_LIGHT_Y  = 3'd5,
        REG_LIGHT_Z  = 3'd6
    } reg_idx_t;

    // Setup sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_CHECK,
        ST_PUSH_MUL,
        ST_PUSH_ACC,
        ST_DIV,
        ST_SCALE_MUL,
        ST_SCALE_ACC
    } setup_state_t;

    // Plane and light registers as seen by the setup sequencer
    typedef struct packed {
        vec3_t normal;
        fx_t   offset;
        vec3_t light;
    } psvp_cfg_t;

    // Setup results handed to the vertex pipeline
    typedef struct packed {
        logic  done;
        vec3_t scaled_light;
    } psvp_stat_t;

    // Clamp a wide signed value to the 32-bit range
    function automatic fx_t sat_fx(input logic signed [63:0] x);
        fx_t r;
        if (x > WIDE_MAX)
            r = FX_MAX;
        else if (x < WIDE_MIN)
            r = FX_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

    // Full-width signed product of two fixed-point words
    function automatic logic signed [63:0] mul_fx(input fx_t a, input fx_t b);
        logic signed [63:0] r;
        r = a * b;
        return r;
    endfunction

endpackage

// ===== hdl/psvp_setup.sv =====
`include "planar_shadow_vertex_projector_assert.svh"

module psvp_setup #(
    parameter int FRAC_BITS = psvp_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psvp_pkg::psvp_cfg_t   cfg,
    input  logic                  restart,
    output psvp_pkg::psvp_stat_t  stat
);
    import psvp_pkg::*;

    localparam int  QW    = 2 * FRAC_BITS + 1;
    localparam int  CNT_W = $clog2(QW);
    localparam fx_t HALF  = 32'sd1 <<< (FRAC_BITS - 1);

    setup_state_t       state_reg, state_next;
    logic               done_reg, done_next;
    logic [1:0]         idx_reg, idx_next;
    logic               pushed_reg, pushed_next;
    logic signed [33:0] acc_reg, acc_next;
    vec3_t              l_reg, l_next;
    fx_t                k_reg, k_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [30:0]        rem_reg, rem_next;
    logic [QW-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [30:0]        dvs_reg, dvs_next;
    fx_t                recip_reg, recip_next;
    vec3_t              scaled_reg, scaled_next;

    fx_t                mul_a, mul_b;
    fx_t                fm;
    fx_t                d_sat;
    fx_t                d_pos;
    logic [31:0]        trial;
    logic [31:0]        diff;
    logic               ge;
    logic [63:0]        quo_wide;

    // Shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_PUSH_MUL:
            begin
                mul_a = k_reg;
                mul_b = $signed(cfg.normal[idx_reg]);
            end
            ST_SCALE_MUL:
            begin
                mul_a = $signed(l_reg[idx_reg]);
                mul_b = recip_reg;
            end
            default:
            begin
                mul_a = $signed(l_reg[idx_reg]);
                mul_b = $signed(cfg.normal[idx_reg]);
            end
        endcase
        prod_next = mul_fx(mul_a, mul_b);
    end

    // Scaled product, dot result and one division step
    always_comb
    begin
        fm       = sat_fx(prod_reg >>> FRAC_BITS);
        d_sat    = sat_fx(64'(acc_reg));
        d_pos    = (d_sat < 32'sd1) ? 32'sd1 : d_sat;
        trial    = {rem_reg, (cnt_reg == CNT_W'(2 * FRAC_BITS))};
        ge       = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        quo_next = {quo_reg[QW-2:0], ge};
        quo_wide = 64'(quo_next);
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        done_next   = done_reg;
        idx_next    = idx_reg;
        pushed_next = pushed_reg;
        acc_next    = acc_reg;
        l_next      = l_reg;
        k_next      = k_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        dvs_next    = dvs_reg;
        recip_next  = recip_reg;
        scaled_next = scaled_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!done_reg)
                begin
                    l_next      = cfg.light;
                    acc_next    = '0;
                    idx_next    = '0;
                    pushed_next = 1'b0;
                    state_next  = ST_DOT_MUL;
                end
            end
            ST_DOT_MUL:
            begin
                state_next = ST_DOT_ACC;
            end
            ST_DOT_ACC:
            begin
                acc_next = acc_reg + 34'(fm);
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = ST_CHECK;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DOT_MUL;
                end
            end
            ST_CHECK:
            begin
                // Push the light along the normal, once per setup, when the dot is below one half
                if (!pushed_reg && (d_sat < HALF))
                begin
                    k_next      = sat_fx(64'(HALF) - 64'(d_sat));
                    pushed_next = 1'b1;
                    idx_next    = '0;
                    state_next  = ST_PUSH_MUL;
                end
                else
                begin
                    dvs_next   = d_pos[30:0];
                    rem_next   = '0;
                    cnt_next   = CNT_W'(2 * FRAC_BITS);
                    state_next = ST_DIV;
                end
            end
            ST_PUSH_MUL:
            begin
                state_next = ST_PUSH_ACC;
            end
            ST_PUSH_ACC:
            begin
                l_next[idx_reg] = sat_fx(64'($signed(l_reg[idx_reg])) + 64'(fm));
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = ST_DOT_MUL;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_PUSH_MUL;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? diff[30:0] : trial[30:0];
                if (cnt_reg == '0)
                begin
                    recip_next = (|quo_wide[63:31]) ? FX_MAX : fx_t'(quo_wide[31:0]);
                    idx_next   = '0;
                    state_next = ST_SCALE_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_SCALE_MUL:
            begin
                state_next = ST_SCALE_ACC;
            end
            ST_SCALE_ACC:
            begin
                scaled_next[idx_reg] = fm;
                if (idx_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SCALE_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write throws away any setup in progress
        if (restart)
        begin
            state_next = ST_IDLE;
            done_next  = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
            pushed_reg <= 1'b0;
            cnt_reg    <= '0;
            scaled_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            idx_reg    <= idx_next;
            pushed_reg <= pushed_next;
            cnt_reg    <= cnt_next;
            scaled_reg <= scaled_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        l_reg     <= l_next;
        k_reg     <= k_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        quo_reg   <= (state_reg == ST_DIV) ? quo_next : '0;
        dvs_reg   <= dvs_next;
        recip_reg <= recip_next;
    end

    assign stat.done         = done_reg;
    assign stat.scaled_light = scaled_reg;

    `PSVP_ASSERT_IMPL(a_done_only_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `PSVP_ASSERT_NEXT(a_restart_clears, clk, rst_n, restart, !done_reg)
    `PSVP_ASSERT_NEXT(a_div_ends, clk, rst_n,
        (state_reg == ST_DIV) && (cnt_reg == '0) && !restart,
        state_reg == ST_SCALE_MUL)

endmodule

// ===== hdl/planar_shadow_vertex_projector.sv =====
// Projects a stream of vertices onto a ground plane along a light direction, in signed
// fixed point with FRAC_BITS fraction bits (Q16.16 by default). After reset and after
// every write to one of the seven registers, a setup sequencer on a single shared
// multiplier forms the light dot normal, pushes the light along the normal when that
// dot is below one half, takes the reciprocal with a one-bit-per-cycle divider and
// scales the light by it; this starts at once, and s_axis_tready stays low until it
// ends. From then on one vertex is taken every cycle while the output does not stall,
// and back-pressure on the output stalls the four-stage pipeline without loss. The
// user must write registers only while no vertex is in flight; nothing enforces it.
`include "planar_shadow_vertex_projector_assert.svh"

module planar_shadow_vertex_projector #(
    parameter int FRAC_BITS = psvp_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Vertex input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // vert_x [31:0], vert_y [63:32], vert_z [95:64]
    input  logic        s_axis_tlast,   // last_vertex
    // Projected vertex output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // proj_x [31:0], proj_y [63:32], proj_z [95:64]
    output logic        m_axis_tlast    // last_out
);
    import psvp_pkg::*;

    localparam fx_t ONE = 32'sd1 <<< FRAC_BITS;

    // Configuration registers
    vec3_t      normal_reg;
    vec3_t      light_reg;
    fx_t        offset_reg;
    logic       cfg_restart;
    psvp_cfg_t  cfg;
    psvp_stat_t stat;

    // Pipeline stages
    logic               valid1_reg, valid2_reg, valid3_reg, valid4_reg;
    logic               en1, en2, en3, en4;
    logic               last1_reg, last2_reg, last3_reg, last4_reg;
    fx_t                v1_reg [3];
    fx_t                v2_reg [3];
    fx_t                v3_reg [3];
    fx_t                r4_reg [3];
    logic signed [63:0] p1_reg [3];
    logic signed [63:0] p3_reg [3];
    fx_t                h2_reg;
    fx_t                vin [3];
    fx_t                h_next;
    logic               accept;

    // Register writes
    assign cfg_restart = cfg_wr_en && (cfg_index <= REG_LIGHT_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg <= {ONE, 32'sd0, 32'sd0};
            light_reg  <= {ONE, 32'sd0, 32'sd0};
            offset_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_NORMAL_X: normal_reg[0] <= cfg_data;
                REG_NORMAL_Y: normal_reg[1] <= cfg_data;
                REG_NORMAL_Z: normal_reg[2] <= cfg_data;
                REG_OFFSET:   offset_reg    <= cfg_data;
                REG_LIGHT_X:  light_reg[0]  <= cfg_data;
                REG_LIGHT_Y:  light_reg[1]  <= cfg_data;
                REG_LIGHT_Z:  light_reg[2]  <= cfg_data;
                default:      offset_reg    <= offset_reg;
            endcase
        end
    end

    assign cfg.normal = normal_reg;
    assign cfg.offset = offset_reg;
    assign cfg.light  = light_reg;

    psvp_setup #(
        .FRAC_BITS (FRAC_BITS)
    ) u_setup (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (cfg_restart),
        .stat    (stat)
    );

    // Per-stage advance; a stage moves when empty or when the next one moves
    assign en4 = !valid4_reg || m_axis_tready;
    assign en3 = !valid3_reg || en4;
    assign en2 = !valid2_reg || en3;
    assign en1 = !valid1_reg || en2;

    assign s_axis_tready = stat.done && en1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign vin[0] = s_axis_tdata[31:0];
    assign vin[1] = s_axis_tdata[63:32];
    assign vin[2] = s_axis_tdata[95:64];

    // Height above the plane from the stage 1 products
    assign h_next = sat_fx(64'(sat_fx(p1_reg[0] >>> FRAC_BITS))
                         + 64'(sat_fx(p1_reg[1] >>> FRAC_BITS))
                         + 64'(sat_fx(p1_reg[2] >>> FRAC_BITS))
                         + 64'(offset_reg));

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                valid1_reg <= accept;
            if (en2)
                valid2_reg <= valid1_reg;
            if (en3)
                valid3_reg <= valid2_reg;
            if (en4)
                valid4_reg <= valid3_reg;
        end
    end

    // Payload: vertex times normal, height, light times height, subtract
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            last1_reg <= s_axis_tlast;
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i] <= vin[i];
                p1_reg[i] <= mul_fx(vin[i], $signed(normal_reg[i]));
            end
        end
        if (en2)
        begin
            last2_reg <= last1_reg;
            h2_reg    <= h_next;
            for (int i = 0; i < 3; i++)
                v2_reg[i] <= v1_reg[i];
        end
        if (en3)
        begin
            last3_reg <= last2_reg;
            for (int i = 0; i < 3; i++)
            begin
                v3_reg[i] <= v2_reg[i];
                p3_reg[i] <= mul_fx($signed(stat.scaled_light[i]), h2_reg);
            end
        end
        if (en4)
        begin
            last4_reg <= last3_reg;
            for (int i = 0; i < 3; i++)
                r4_reg[i] <= sat_fx(64'(v3_reg[i]) - 64'(sat_fx(p3_reg[i] >>> FRAC_BITS)));
        end
    end

    assign m_axis_tvalid = valid4_reg;
    assign m_axis_tdata  = {r4_reg[2], r4_reg[1], r4_reg[0]};
    assign m_axis_tlast  = last4_reg;

    `PSVP_ASSERT_IMPL(a_ready_after_setup, clk, rst_n, s_axis_tready, stat.done)
    `PSVP_ASSERT_NEXT(a_write_blocks_input, clk, rst_n, cfg_restart, !s_axis_tready)
    `PSVP_ASSERT_NEXT(a_stage1_holds, clk, rst_n, valid1_reg && !en2, valid1_reg)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import psvp_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int unsigned Q_UNIT = 1 << FRAC;
    localparam fx_t Q_ONE = fx_t'(Q_UNIT);
    localparam fx_t Q_HALF = fx_t'(Q_UNIT / 2);
    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int QUIET_LIMIT = 3000;

    typedef logic signed [63:0] wide_t;
    localparam wide_t Q_TOP = 64'sd2147483647;
    localparam wide_t Q_BOT = -64'sd2147483648;

    typedef struct packed {
        fx_t  x;
        fx_t  y;
        fx_t  z;
        logic last;
    } proj_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // vert_x [31:0], vert_y [63:32], vert_z [95:64]
    logic        s_axis_tlast;   // last_vertex
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // proj_x [31:0], proj_y [63:32], proj_z [95:64]
    logic        m_axis_tlast;   // last_out

    // Predictor copy of the plane, the light and the cached scaled light
    wide_t plane_n [3];
    wide_t plane_ofs;
    wide_t light_dir [3];
    wide_t scaled_light [3];
    bit    scaled_ok;

    proj_t projections_due [$];

    bit src_jitter = 1'b1;
    bit sink_jitter = 1'b1;
    int vertices_sent = 0;
    int results_seen = 0;
    int writes_done = 0;
    int rebuilds = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    planar_shadow_vertex_projector #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Fixed-point arithmetic of the predictor

    function automatic wide_t clamp32(input wide_t v);
        if (v > Q_TOP)
            return Q_TOP;
        if (v < Q_BOT)
            return Q_BOT;
        return v;
    endfunction

    // Full product, floor shift, saturate
    function automatic wide_t qmul(input wide_t a, input wide_t b);
        wide_t p;
        p = a * b;
        return clamp32(p >>> FRAC);
    endfunction

    function automatic wide_t qdot(input wide_t a0, input wide_t a1, input wide_t a2,
                                   input wide_t b0, input wide_t b1, input wide_t b2);
        return qmul(a0, b0) + qmul(a1, b1) + qmul(a2, b2);
    endfunction

    function automatic void reset_predictor();
        int i;
        for (i = 0; i < 3; i++)
        begin
            plane_n[i] = 0;
            light_dir[i] = 0;
            scaled_light[i] = 0;
        end
        plane_n[2] = wide_t'(Q_ONE);
        light_dir[2] = wide_t'(Q_ONE);
        plane_ofs = 0;
        scaled_ok = 1'b0;
    endfunction

    // Form L/(L.n), pushing L along n first when the dot falls below one half
    function automatic void rebuild_scaled_light();
        wide_t l [3];
        wide_t half;
        wide_t d;
        wide_t k;
        wide_t rc;
        int i;
        half = 64'sd1 <<< (FRAC - 1);
        for (i = 0; i < 3; i++)
            l[i] = light_dir[i];
        d = clamp32(qdot(l[0], l[1], l[2], plane_n[0], plane_n[1], plane_n[2]));
        if (d < half)
        begin
            k = clamp32(half - d);
            for (i = 0; i < 3; i++)
                l[i] = clamp32(l[i] + qmul(k, plane_n[i]));
            d = clamp32(qdot(l[0], l[1], l[2], plane_n[0], plane_n[1], plane_n[2]));
        end
        // Non-positive divisor falls back to one LSB
        if (d < 1)
            d = 1;
        rc = clamp32((64'sd1 <<< (2 * FRAC)) / d);
        for (i = 0; i < 3; i++)
            scaled_light[i] = qmul(l[i], rc);
        scaled_ok = 1'b1;
        rebuilds++;
    endfunction

    function automatic void apply_write(input logic [2:0] idx, input logic [31:0] data);
        wide_t v;
        v = wide_t'($signed(data));
        case (idx)
            REG_NORMAL_X: plane_n[0] = v;
            REG_NORMAL_Y: plane_n[1] = v;
            REG_NORMAL_Z: plane_n[2] = v;
            REG_OFFSET:   plane_ofs = v;
            REG_LIGHT_X:  light_dir[0] = v;
            REG_LIGHT_Y:  light_dir[1] = v;
            REG_LIGHT_Z:  light_dir[2] = v;
            default:      return;
        endcase
        scaled_ok = 1'b0;
    endfunction

    function automatic proj_t project_vertex(input logic [95:0] data, input logic last);
        wide_t v [3];
        wide_t h;
        proj_t r;
        int i;
        if (!scaled_ok)
            rebuild_scaled_light();
        for (i = 0; i < 3; i++)
            v[i] = wide_t'($signed(data[32*i +: 32]));
        h = clamp32(qdot(v[0], v[1], v[2], plane_n[0], plane_n[1], plane_n[2]) + plane_ofs);
        r.x = fx_t'(clamp32(v[0] - qmul(scaled_light[0], h)));
        r.y = fx_t'(clamp32(v[1] - qmul(scaled_light[1], h)));
        r.z = fx_t'(clamp32(v[2] - qmul(scaled_light[2], h)));
        r.last = last;
        return r;
    endfunction

    function automatic void check_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s in result %0d: expected %0d (%h), got %0d (%h)",
                         label, results_seen, $signed(want), want, $signed(got), got);
        end
    endfunction

    // Track register writes and vertex transfers, check each result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                apply_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                projections_due.push_back(project_vertex(s_axis_tdata, s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (projections_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("MISMATCH unexpected result %0d: data %h last %b",
                                 results_seen, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    proj_t want;
                    want = projections_due.pop_front();
                    check_field("proj_x", want.x, m_axis_tdata[31:0]);
                    check_field("proj_y", want.y, m_axis_tdata[63:32]);
                    check_field("proj_z", want.z, m_axis_tdata[95:64]);
                    check_field("last_out", {31'b0, want.last}, {31'b0, m_axis_tlast});
                end
                results_seen++;
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Apply back-pressure in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_jitter && stall_left == 0 && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // Stimulus helpers

    function automatic fx_t rand_span(input int unsigned r);
        logic [31:0] u;
        u = $urandom_range(0, 2 * r);
        return fx_t'(u - r);
    endfunction

    function automatic fx_t extreme_word();
        case ($urandom_range(0, 5))
            0: return FX_MAX;
            1: return FX_MIN;
            2: return fx_t'(0);
            3: return fx_t'(1);
            4: return fx_t'(-1);
            default: return Q_ONE;
        endcase
    endfunction

    function automatic fx_t pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return extreme_word();
        if (sel <= 2)
            return fx_t'($urandom);
        return rand_span(256 * Q_UNIT);
    endfunction

    function automatic fx_t pick_reg_value(input logic [2:0] idx);
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return extreme_word();
        if (sel <= 2)
            return fx_t'($urandom);
        case (idx)
            REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z: return rand_span(Q_UNIT);
            REG_OFFSET: return rand_span(64 * Q_UNIT);
            default: return rand_span(4 * Q_UNIT);
        endcase
    endfunction

    // Hold the input low until every projection has come back
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (projections_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input fx_t value);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        writes_done++;
    endtask

    task automatic set_config(input fx_t nx, input fx_t ny, input fx_t nz, input fx_t ofs,
                              input fx_t lx, input fx_t ly, input fx_t lz);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_OFFSET, ofs);
        write_reg(REG_LIGHT_X, lx);
        write_reg(REG_LIGHT_Y, ly);
        write_reg(REG_LIGHT_Z, lz);
    endtask

    // Offer one vertex, with an optional gap first, and hold it until the transfer
    task automatic send_vertex(input fx_t x, input fx_t y, input fx_t z, input logic last);
        @(negedge clk);
        if (src_jitter && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {z, y, x};
        s_axis_tlast = last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        vertices_sent++;
    endtask

    // Tests

    // Reset plane and light: z collapses to zero, x and y pass through
    task automatic test_reset_plane();
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(FX_MAX, FX_MAX, FX_MAX, 1'b0);
        send_vertex(FX_MIN, FX_MIN, FX_MIN, 1'b1);
        send_vertex(fx_t'(1), fx_t'(-1), Q_ONE, 1'b0);
        send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'b1);
        wait_drained();
    endtask

    task automatic test_setup_cases();
        // Light against the normal: pushed back to a dot of one half
        set_config(0, 0, Q_ONE, 0, Q_HALF, 0, -Q_ONE);
        send_vertex(3 * Q_ONE, 2 * Q_ONE, 5 * Q_ONE, 1'b0);
        send_vertex(-Q_ONE, 4 * Q_ONE, -2 * Q_ONE, 1'b1);
        // Dot exactly one half: no push
        set_config(0, 0, Q_ONE, 2 * Q_ONE, 0, Q_ONE, Q_HALF);
        send_vertex(Q_ONE, -3 * Q_ONE, 7 * Q_ONE, 1'b1);
        // One LSB below one half, light z alone rewritten
        write_reg(REG_LIGHT_Z, Q_HALF - 1);
        send_vertex(Q_ONE, -3 * Q_ONE, 7 * Q_ONE, 1'b1);
        // Zero normal: dot stays zero, divisor falls back to one LSB, reciprocal saturates
        set_config(0, 0, 0, 3 * Q_ONE, Q_ONE, -2 * Q_ONE, 0);
        send_vertex(Q_ONE, Q_ONE, Q_ONE, 1'b0);
        send_vertex(0, 0, 0, 1'b1);
        // Every register at its top value
        set_config(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
        send_vertex(FX_MAX, FX_MIN, 0, 1'b0);
        send_vertex(FX_MIN, FX_MAX, fx_t'(1), 1'b1);
        // Large normal, large negative light: push factor saturates
        set_config(FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
        send_vertex(Q_ONE, -Q_ONE, 0, 1'b0);
        send_vertex(FX_MAX, FX_MAX, FX_MIN, 1'b1);
        // Every register at its bottom value
        set_config(FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
        send_vertex(FX_MIN, 0, FX_MAX, 1'b1);
        // Spare index: write ignored, cached light kept
        write_reg(REG_SPARE, fx_t'($urandom));
        send_vertex(Q_ONE, 2 * Q_ONE, -Q_ONE, 1'b1);
        wait_drained();
    endtask

    // Batches of vertices under changing planes, lights and idling
    task automatic test_random_batches(input int target);
        int len;
        int k;
        int n;
        logic [2:0] idx;
        logic last;
        while (vertices_sent < target)
        begin
            src_jitter = ($urandom_range(0, 3) != 0);
            sink_jitter = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    set_config(pick_reg_value(REG_NORMAL_X), pick_reg_value(REG_NORMAL_Y),
                               pick_reg_value(REG_NORMAL_Z), pick_reg_value(REG_OFFSET),
                               pick_reg_value(REG_LIGHT_X), pick_reg_value(REG_LIGHT_Y),
                               pick_reg_value(REG_LIGHT_Z));
                else
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                    begin
                        idx = 3'($urandom_range(0, 7));
                        write_reg(idx, pick_reg_value(idx));
                    end
                end
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
            for (k = 0; k < len; k++)
            begin
                last = (k == len - 1);
                // Misplace the batch mark now and then
                if ($urandom_range(0, 19) == 0)
                    last = ~last;
                send_vertex(pick_coord(), pick_coord(), pick_coord(), last);
                if (k != len - 1 && $urandom_range(0, 40) == 0)
                    wait_drained();
            end
        end
        wait_drained();
    endtask

    // Back-to-back vertices with no idling on either side
    task automatic test_full_rate(input int count);
        int k;
        src_jitter = 1'b0;
        sink_jitter = 1'b0;
        set_config(pick_reg_value(REG_NORMAL_X), pick_reg_value(REG_NORMAL_Y),
                   pick_reg_value(REG_NORMAL_Z), pick_reg_value(REG_OFFSET),
                   pick_reg_value(REG_LIGHT_X), pick_reg_value(REG_LIGHT_Y),
                   pick_reg_value(REG_LIGHT_Z));
        for (k = 0; k < count; k++)
            send_vertex(pick_coord(), pick_coord(), pick_coord(), (k % 50) == 49);
        wait_drained();
    endtask

    initial
    begin
        int leftover;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_NORMAL_X;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        reset_predictor();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_plane();
        test_setup_cases();
        test_random_batches(1350);
        test_full_rate(200);

        // Let any stray result show up
        repeat (20) @(posedge clk);
        leftover = projections_due.size();
        if (leftover != 0)
            $display("ERROR: %0d projections never arrived", leftover);

        $display("Run covered %0d vertices, %0d register writes, %0d light setups;",
                 vertices_sent, writes_done, rebuilds);
        $display("%0d projections checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && leftover == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== planar_shadow_vertex_projector.f =====
+incdir+hdl
hdl/psvp_pkg.sv
hdl/psvp_setup.sv
hdl/planar_shadow_vertex_projector.sv
test/tb.sv
